// ===== design/zcco_pkg.sv =====
package zcco_pkg;

    // result slots one pixel can produce (vertical, horizontal, last column)
    localparam int RES_SLOTS = 3;

    // result queue, power-of-two depth
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = 3;
    localparam int FIFO_CNT_W = 4;

    localparam int ROW_BITS   = 16;
    localparam int COLOR_BITS = 24;
    localparam int CFG_W_BITS = 12;
    localparam int CFG_DATA_W = 16;

    localparam logic [7:0] RED_FULL = 8'd255;

    // configuration register indexes
    localparam logic CFG_IDX_WIDTH  = 1'b0;
    localparam logic CFG_IDX_HEIGHT = 1'b1;

    localparam logic [CFG_W_BITS-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [ROW_BITS-1:0]   HEIGHT_RESET = 16'd480;

    // per-pixel control carried from the accept stage to the marking stage
    typedef struct packed {
        logic vld;
        logic up_row;
        logic col_nz;
        logic last_col;
        logic last_row;
    } t_pix_ctl;

    typedef struct packed {
        logic       marked;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       run_last;
        logic       frame_end;
    } t_res_info;

endpackage

// ===== design/zcco_line_store.sv =====
module zcco_line_store #(
    parameter int LEVEL_BITS = 16,
    parameter int MAX_WIDTH  = 2048,
    localparam int ADDR_W    = $clog2(MAX_WIDTH),
    localparam int MEM_W     = LEVEL_BITS + zcco_pkg::COLOR_BITS + 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [MEM_W-1:0]  i_wr_data,
    input  logic              i_hm_wr_en,
    input  logic [ADDR_W-1:0] i_hm_wr_addr,
    input  logic              i_hm_wr_bit,
    output logic [MEM_W-1:0]  o_rd_data,
    output logic              o_rd_hmark
);

    // level, color and vertical skip per column
    logic [MEM_W-1:0] r_line [MAX_WIDTH];
    // horizontal marks of the previous row
    logic             r_hmark [MAX_WIDTH];

    logic [MEM_W-1:0] r_rd_data;
    logic             r_rd_hmark;
    logic             r_fw_hit;
    logic [MEM_W-1:0] r_fw_data;
    logic             r_hfw_hit;
    logic             r_hfw_bit;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_line[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_line[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_hm_wr_en) begin
            r_hmark[i_hm_wr_addr] <= i_hm_wr_bit;
        end
        if (i_rd_en) begin
            r_rd_hmark <= r_hmark[i_rd_addr];
        end
    end

    // a write landing on the same edge as the read returns old data: bypass it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw_hit  <= 1'b0;
            r_hfw_hit <= 1'b0;
        end else if (i_rd_en) begin
            r_fw_hit  <= i_wr_en && (i_wr_addr == i_rd_addr);
            r_hfw_hit <= i_hm_wr_en && (i_hm_wr_addr == i_rd_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_fw_data <= i_wr_data;
            r_hfw_bit <= i_hm_wr_bit;
        end
    end

    assign o_rd_data  = r_fw_hit ? r_fw_data : r_rd_data;
    assign o_rd_hmark = r_hfw_hit ? r_hfw_bit : r_rd_hmark;

endmodule

// ===== design/zcco_marker.sv =====
module zcco_marker #(
    parameter int LEVEL_BITS = 16,
    parameter int MAX_WIDTH  = 2048,
    localparam int COL_W     = $clog2(MAX_WIDTH),
    localparam int MEM_W     = LEVEL_BITS + zcco_pkg::COLOR_BITS + 1
) (
    input  logic                                                i_clk,
    input  logic                                                i_rst_n,
    input  zcco_pkg::t_pix_ctl                                  i_ctl,
    input  logic [zcco_pkg::ROW_BITS-1:0]                       i_row,
    input  logic [COL_W-1:0]                                    i_col,
    input  logic [LEVEL_BITS-1:0]                               i_level,
    input  logic [zcco_pkg::COLOR_BITS-1:0]                     i_color,
    input  logic [MEM_W-1:0]                                    i_up_data,
    input  logic                                                i_up_hmark,
    output logic                                                o_wr_en,
    output logic [COL_W-1:0]                                    o_wr_addr,
    output logic [MEM_W-1:0]                                    o_wr_data,
    output logic                                                o_hm_wr_en,
    output logic [COL_W-1:0]                                    o_hm_wr_addr,
    output logic                                                o_hm_wr_bit,
    output logic [zcco_pkg::RES_SLOTS-1:0]                      o_res_vld,
    output logic [zcco_pkg::RES_SLOTS-1:0][zcco_pkg::ROW_BITS-1:0] o_res_row,
    output logic [zcco_pkg::RES_SLOTS-1:0][COL_W-1:0]           o_res_col,
    output zcco_pkg::t_res_info [zcco_pkg::RES_SLOTS-1:0]       o_res_info
);

    logic [LEVEL_BITS-1:0]           r_prev_level;
    logic [zcco_pkg::COLOR_BITS-1:0] r_prev_color;
    logic                            r_prev_nvsk;
    logic                            r_hskip;
    logic                            r_dfr_vld;
    logic [COL_W-1:0]                r_dfr_addr;
    logic                            r_dfr_bit;

    logic [LEVEL_BITS-1:0]           up_level;
    logic [zcco_pkg::COLOR_BITS-1:0] up_color;
    logic                            up_vskip;
    logic                            v_cross;
    logic                            v_lt;
    logic                            vmark;
    logic                            nvsk;
    logic                            h_cross;
    logic                            h_lt;
    logic                            hm_prev;
    logic                            nh;
    logic                            n_hskip;

    function automatic logic crosses(input logic [LEVEL_BITS-1:0] a,
                                     input logic [LEVEL_BITS-1:0] b);
        logic a_le;
        logic a_ge;
        logic b_le;
        logic b_ge;
        a_le = a[LEVEL_BITS-1] || (a == '0);
        a_ge = !a[LEVEL_BITS-1];
        b_le = b[LEVEL_BITS-1] || (b == '0);
        b_ge = !b[LEVEL_BITS-1];
        return (a_le && b_ge) || (a_ge && b_le);
    endfunction

    // unsigned magnitude, the most negative value maps to its true size
    function automatic logic [LEVEL_BITS-1:0] mag(input logic [LEVEL_BITS-1:0] a);
        return a[LEVEL_BITS-1] ? (~a + 1'b1) : a;
    endfunction

    function automatic zcco_pkg::t_res_info paint(
        input logic                            mark,
        input logic [zcco_pkg::COLOR_BITS-1:0] color,
        input logic                            run_last,
        input logic                            fend
    );
        zcco_pkg::t_res_info info;
        info.marked    = mark;
        info.blue      = mark ? 8'd0 : color[7:0];
        info.green     = mark ? 8'd0 : color[15:8];
        info.red       = mark ? zcco_pkg::RED_FULL : color[23:16];
        info.run_last  = run_last;
        info.frame_end = fend;
        return info;
    endfunction

    assign up_level = i_up_data[LEVEL_BITS-1:0];
    assign up_color = i_up_data[LEVEL_BITS +: zcco_pkg::COLOR_BITS];
    assign up_vskip = i_up_data[MEM_W-1];

    // vertical pair: row above against this pixel
    assign v_cross = crosses(up_level, i_level);
    assign v_lt    = mag(up_level) < mag(i_level);
    assign vmark   = up_vskip || (v_cross && v_lt);
    assign nvsk    = i_ctl.up_row && !up_vskip && v_cross && !v_lt;

    // horizontal pair: left neighbor against this pixel
    assign h_cross = crosses(r_prev_level, i_level);
    assign h_lt    = mag(r_prev_level) < mag(i_level);
    assign hm_prev = r_hskip || (h_cross && h_lt);
    assign nh      = i_ctl.col_nz && !r_hskip && h_cross && !h_lt;
    assign n_hskip = i_ctl.last_col ? 1'b0 : nh;

    always_comb begin
        o_res_vld[0] = i_ctl.vld && i_ctl.up_row;
        o_res_vld[1] = i_ctl.vld && i_ctl.col_nz && i_ctl.last_row;
        o_res_vld[2] = i_ctl.vld && i_ctl.last_col && i_ctl.last_row;

        o_res_row[0] = i_row - 1'b1;
        o_res_row[1] = i_row;
        o_res_row[2] = i_row;

        o_res_col[0] = i_col;
        o_res_col[1] = i_col - 1'b1;
        o_res_col[2] = i_col;

        o_res_info[0] = paint(vmark || i_up_hmark, up_color,
                              !(o_res_vld[1] || o_res_vld[2]), 1'b0);
        o_res_info[1] = paint(hm_prev || r_prev_nvsk, r_prev_color,
                              !o_res_vld[2], 1'b0);
        o_res_info[2] = paint(nh || nvsk, i_color, 1'b1, 1'b1);
    end

    assign o_wr_en   = i_ctl.vld;
    assign o_wr_addr = i_col;
    assign o_wr_data = {nvsk, i_color, i_level};

    // left neighbor's mark now; the last column's own mark in the next cycle,
    // when the following pixel (column zero), if any, leaves the port free; at once if the last column is column zero
    always_comb begin
        if (i_ctl.vld && i_ctl.col_nz) begin
            o_hm_wr_en   = 1'b1;
            o_hm_wr_addr = i_col - 1'b1;
            o_hm_wr_bit  = hm_prev;
        end else if (i_ctl.vld && i_ctl.last_col) begin
            o_hm_wr_en   = 1'b1;
            o_hm_wr_addr = i_col;
            o_hm_wr_bit  = nh;
        end else begin
            o_hm_wr_en   = r_dfr_vld;
            o_hm_wr_addr = r_dfr_addr;
            o_hm_wr_bit  = r_dfr_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hskip   <= 1'b0;
            r_dfr_vld <= 1'b0;
        end else begin
            r_dfr_vld <= i_ctl.vld && i_ctl.col_nz && i_ctl.last_col;
            if (i_ctl.vld) begin
                r_hskip <= n_hskip;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.vld) begin
            r_prev_level <= i_level;
            r_prev_color <= i_color;
            r_prev_nvsk  <= nvsk;
            r_dfr_addr   <= i_col;
            r_dfr_bit    <= nh;
        end
    end

endmodule

// ===== design/zcco_result_fifo.sv =====
module zcco_result_fifo #(
    parameter int DATA_W = 54
) (
    input  logic                                             i_clk,
    input  logic                                             i_rst_n,
    input  logic [zcco_pkg::RES_SLOTS-1:0]                   i_push_vld,
    input  logic [zcco_pkg::RES_SLOTS-1:0][DATA_W-1:0]       i_push_data,
    input  logic                                             i_pop,
    output logic [zcco_pkg::FIFO_CNT_W-1:0]                  o_count,
    output logic [DATA_W-1:0]                                o_head
);

    logic [DATA_W-1:0]               r_buf [zcco_pkg::FIFO_DEPTH];
    logic [zcco_pkg::FIFO_PTR_W-1:0] r_wr_ptr;
    logic [zcco_pkg::FIFO_PTR_W-1:0] r_rd_ptr;
    logic [zcco_pkg::FIFO_CNT_W-1:0] r_count;

    logic [zcco_pkg::FIFO_PTR_W-1:0] off [zcco_pkg::RES_SLOTS];
    logic [zcco_pkg::FIFO_CNT_W-1:0] n_push;

    // valid slots are packed in order behind the write pointer
    always_comb begin
        logic [zcco_pkg::FIFO_PTR_W-1:0] run;
        run = '0;
        for (int k = 0; k < zcco_pkg::RES_SLOTS; k++) begin
            off[k] = run;
            run    = run + zcco_pkg::FIFO_PTR_W'(i_push_vld[k]);
        end
    end

    assign n_push = zcco_pkg::FIFO_CNT_W'($countones(i_push_vld));

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < zcco_pkg::RES_SLOTS; k++) begin
            if (i_push_vld[k]) begin
                r_buf[r_wr_ptr + off[k]] <= i_push_data[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + zcco_pkg::FIFO_PTR_W'(n_push);
            r_rd_ptr <= r_rd_ptr + zcco_pkg::FIFO_PTR_W'(i_pop);
            r_count  <= r_count + n_push - zcco_pkg::FIFO_CNT_W'(i_pop);
        end
    end

    assign o_count = r_count;
    assign o_head  = r_buf[r_rd_ptr];

endmodule

// ===== design/zero_crossing_contour_overlay_top.sv =====
// order: pixel (r, c) is described once the word for (r+1, c) is accepted and has
//   passed the accept-stage registers and the marking stage into the result queue;
//   in the last row the word for (r, c) also yields (r, c-1) and, at the last column, (r, c) itself
// throughput: one input word per clock while the result queue has room, set by the
//   single read-modify-write pass through the line store; last-row words carry up to three results
// reset: synchronous, active low; clears counters, queue and skip state,
//   loads 640 x 480; line stores are not cleared and need no clearing pass
module zero_crossing_contour_overlay_top #(
    parameter int MAX_WIDTH  = 2048,
    parameter int LEVEL_BITS = 16,
    localparam int COL_W     = $clog2(MAX_WIDTH)
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,

    // pixel input channel
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [7:0]                       i_src_blue,
    input  logic [7:0]                       i_src_green,
    input  logic [7:0]                       i_src_red,
    input  logic [LEVEL_BITS-1:0]            i_level,

    // result output channel
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [zcco_pkg::ROW_BITS-1:0]    o_out_row,
    output logic [COL_W-1:0]                 o_out_col,
    output logic                             o_marked,
    output logic [7:0]                       o_out_blue,
    output logic [7:0]                       o_out_green,
    output logic [7:0]                       o_out_red,
    output logic                             o_run_last,
    output logic                             o_frame_end,

    // configuration write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic                             i_cfg_index,
    input  logic [zcco_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int CNT_W  = COL_W + 1;
    localparam int XW     = (CNT_W > zcco_pkg::CFG_W_BITS) ? CNT_W : zcco_pkg::CFG_W_BITS;
    localparam int MEM_W  = LEVEL_BITS + zcco_pkg::COLOR_BITS + 1;
    localparam int INFO_W = $bits(zcco_pkg::t_res_info);
    localparam int RES_W  = zcco_pkg::ROW_BITS + COL_W + INFO_W;

    // configuration registers
    logic [zcco_pkg::CFG_W_BITS-1:0] r_cfg_width;
    logic [zcco_pkg::ROW_BITS-1:0]   r_cfg_height;

    // raster position of the next accepted word
    logic [COL_W-1:0]                r_col_count;
    logic [zcco_pkg::ROW_BITS-1:0]   r_row_count;

    // accept stage -> marking stage
    zcco_pkg::t_pix_ctl              r_s1_ctl;
    logic [zcco_pkg::ROW_BITS-1:0]   r_s1_row;
    logic [COL_W-1:0]                r_s1_col;
    logic [LEVEL_BITS-1:0]           r_s1_level;
    logic [zcco_pkg::COLOR_BITS-1:0] r_s1_color;

    logic                            in_acc;
    logic [XW-1:0]                   w_raw;
    logic [CNT_W-1:0]                w_eff;
    logic [CNT_W-1:0]                c_ext;
    logic [CNT_W-1:0]                c_eff;
    logic [COL_W-1:0]                cur_col;
    logic [zcco_pkg::ROW_BITS-1:0]   h_eff;
    logic                            last_col;
    logic                            last_row;
    logic [COL_W-1:0]                n_col_count;
    logic [zcco_pkg::ROW_BITS-1:0]   n_row_count;

    logic [MEM_W-1:0]                up_data;
    logic                            up_hmark;
    logic                            wr_en;
    logic [COL_W-1:0]                wr_addr;
    logic [MEM_W-1:0]                wr_data;
    logic                            hm_wr_en;
    logic [COL_W-1:0]                hm_wr_addr;
    logic                            hm_wr_bit;

    logic [zcco_pkg::RES_SLOTS-1:0]                              res_vld;
    logic [zcco_pkg::RES_SLOTS-1:0][zcco_pkg::ROW_BITS-1:0]      res_row;
    logic [zcco_pkg::RES_SLOTS-1:0][COL_W-1:0]                   res_col;
    zcco_pkg::t_res_info [zcco_pkg::RES_SLOTS-1:0]               res_info;
    logic [zcco_pkg::RES_SLOTS-1:0][RES_W-1:0]                   push_data;

    logic [zcco_pkg::FIFO_CNT_W-1:0] fifo_count;
    logic [zcco_pkg::FIFO_CNT_W-1:0] fifo_need;
    logic [RES_W-1:0]                head;
    zcco_pkg::t_res_info             head_info;
    logic                            out_pop;

    // ---------------------------------------------------------------
    // configuration, always ready
    // ---------------------------------------------------------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= zcco_pkg::WIDTH_RESET;
            r_cfg_height <= zcco_pkg::HEIGHT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                zcco_pkg::CFG_IDX_WIDTH: begin
                    r_cfg_width <= i_cfg_data[zcco_pkg::CFG_W_BITS-1:0];
                end
                zcco_pkg::CFG_IDX_HEIGHT: begin
                    r_cfg_height <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // accept stage: raster position and edge flags
    // ---------------------------------------------------------------
    // width of zero acts as one, anything past the line store as its size
    assign w_raw = XW'(r_cfg_width);
    assign w_eff = (w_raw == '0) ? CNT_W'(1) :
                   (w_raw > XW'(MAX_WIDTH)) ? CNT_W'(MAX_WIDTH) : CNT_W'(w_raw);

    // a column count left past a shrunk width counts as the last column
    assign c_ext   = CNT_W'(r_col_count);
    assign c_eff   = (c_ext >= w_eff) ? (w_eff - 1'b1) : c_ext;
    assign cur_col = c_eff[COL_W-1:0];

    assign h_eff    = (r_cfg_height == '0) ? zcco_pkg::ROW_BITS'(1) : r_cfg_height;
    assign last_col = (c_eff + 1'b1) >= w_eff;
    assign last_row = ({1'b0, r_row_count} + 1'b1) >= {1'b0, h_eff};

    // room for this word's results and those of the word still in flight
    assign fifo_need  = fifo_count + (r_s1_ctl.vld ? zcco_pkg::FIFO_CNT_W'(zcco_pkg::RES_SLOTS)
                                                   : '0);
    assign o_in_stall = fifo_need > zcco_pkg::FIFO_CNT_W'(zcco_pkg::FIFO_DEPTH
                                                         - zcco_pkg::RES_SLOTS);
    assign in_acc     = i_in_valid && !o_in_stall;

    always_comb begin
        n_col_count = r_col_count;
        n_row_count = r_row_count;
        if (in_acc) begin
            if (last_col) begin
                n_col_count = '0;
                n_row_count = last_row ? '0 : (r_row_count + 1'b1);
            end else begin
                n_col_count = cur_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_count <= '0;
            r_row_count <= '0;
            r_s1_ctl    <= '0;
        end else begin
            r_col_count       <= n_col_count;
            r_row_count       <= n_row_count;
            r_s1_ctl.vld      <= in_acc;
            r_s1_ctl.up_row   <= r_row_count != '0;
            r_s1_ctl.col_nz   <= cur_col != '0;
            r_s1_ctl.last_col <= last_col;
            r_s1_ctl.last_row <= last_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_row   <= r_row_count;
            r_s1_col   <= cur_col;
            r_s1_level <= i_level;
            r_s1_color <= {i_src_red, i_src_green, i_src_blue};
        end
    end

    // ---------------------------------------------------------------
    // line store: read at accept, written back by the marking stage
    // ---------------------------------------------------------------
    zcco_line_store #(
        .LEVEL_BITS (LEVEL_BITS),
        .MAX_WIDTH  (MAX_WIDTH)
    ) u_line_store (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rd_en      (in_acc),
        .i_rd_addr    (cur_col),
        .i_wr_en      (wr_en),
        .i_wr_addr    (wr_addr),
        .i_wr_data    (wr_data),
        .i_hm_wr_en   (hm_wr_en),
        .i_hm_wr_addr (hm_wr_addr),
        .i_hm_wr_bit  (hm_wr_bit),
        .o_rd_data    (up_data),
        .o_rd_hmark   (up_hmark)
    );

    // ---------------------------------------------------------------
    // marking stage: both pair tests, skip state, results
    // ---------------------------------------------------------------
    zcco_marker #(
        .LEVEL_BITS (LEVEL_BITS),
        .MAX_WIDTH  (MAX_WIDTH)
    ) u_marker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (r_s1_ctl),
        .i_row        (r_s1_row),
        .i_col        (r_s1_col),
        .i_level      (r_s1_level),
        .i_color      (r_s1_color),
        .i_up_data    (up_data),
        .i_up_hmark   (up_hmark),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data),
        .o_hm_wr_en   (hm_wr_en),
        .o_hm_wr_addr (hm_wr_addr),
        .o_hm_wr_bit  (hm_wr_bit),
        .o_res_vld    (res_vld),
        .o_res_row    (res_row),
        .o_res_col    (res_col),
        .o_res_info   (res_info)
    );

    // ---------------------------------------------------------------
    // result queue, parts the output from the pixel pipeline
    // ---------------------------------------------------------------
    always_comb begin
        for (int k = 0; k < zcco_pkg::RES_SLOTS; k++) begin
            push_data[k] = {res_row[k], res_col[k], res_info[k]};
        end
    end

    assign out_pop = o_out_valid && !i_out_stall;

    zcco_result_fifo #(
        .DATA_W (RES_W)
    ) u_result_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_vld  (res_vld),
        .i_push_data (push_data),
        .i_pop       (out_pop),
        .o_count     (fifo_count),
        .o_head      (head)
    );

    assign o_out_valid = fifo_count != '0;
    assign head_info   = head[INFO_W-1:0];
    assign o_out_row   = head[RES_W-1 -: zcco_pkg::ROW_BITS];
    assign o_out_col   = head[INFO_W +: COL_W];
    assign o_marked    = head_info.marked;
    assign o_out_blue  = head_info.blue;
    assign o_out_green = head_info.green;
    assign o_out_red   = head_info.red;
    assign o_run_last  = head_info.run_last;
    assign o_frame_end = head_info.frame_end;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    // the stall threshold keeps the queue from overflowing
    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fifo_count <= zcco_pkg::FIFO_CNT_W'(zcco_pkg::FIFO_DEPTH))
        else $error("result queue overflow");

    // a last-column word wraps the column counter, so the deferred mark
    // write meets either no word or a column-zero word, both of which leave the port free
    a_col_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_ctl.vld && r_s1_ctl.last_col) |-> (r_col_count == '0))
        else $error("column counter did not wrap after last column");

    // the frame's final pixel is the last result of its word
    a_fend_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_end) |-> o_run_last)
        else $error("frame end without run last");

endmodule

// ===== test/zero_crossing_contour_overlay_top_tb.sv =====
`timescale 1ns / 1ps

module zero_crossing_contour_overlay_top_tb;

    import zcco_pkg::*;

    localparam int MAXW          = 2048;
    localparam int RAND_ITEMS    = 370;
    localparam int SETTLE_CYCLES = 8;
    localparam int QUIET_LIMIT   = 5000;
    localparam int MAX_PRINTS    = 60;

    // hand-picked levels for the 4 x 3 opening frame:
    // first smaller, second smaller with skip, ties, zeros, full-scale extremes
    localparam int OPEN_LEVELS [12] = '{3, -5, 2, -2,
                                        0, 0, -32768, 32767,
                                        10, -10, 7, 7};

    // one pixel word as it enters the block
    typedef struct packed {
        logic [7:0]        blue;
        logic [7:0]        green;
        logic [7:0]        red;
        logic signed [15:0] level;
    } pix_word_t;

    // one described pixel as it leaves the block
    typedef struct {
        bit [15:0] row;
        bit [10:0] col;
        bit        marked;
        bit [7:0]  blue;
        bit [7:0]  green;
        bit [7:0]  red;
        bit        run_last;
        bit        frame_end;
    } px_result_t;

    // dut ports
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_src_blue  = '0;
    logic [7:0]  i_src_green = '0;
    logic [7:0]  i_src_red   = '0;
    logic [15:0] i_level     = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [15:0] o_out_row;
    logic [10:0] o_out_col;
    logic        o_marked;
    logic [7:0]  o_out_blue;
    logic [7:0]  o_out_green;
    logic [7:0]  o_out_red;
    logic        o_run_last;
    logic        o_frame_end;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = CFG_IDX_WIDTH;
    logic [15:0] i_cfg_data  = '0;

    // pending pixel words and expected described pixels
    pix_word_t  pixel_q [$];
    px_result_t expected_px [$];

    // shadow of the block state, reset values
    int          lv_line    [MAXW];
    bit [23:0]   color_line [MAXW];
    bit          hmark_line [MAXW];
    bit          vskip_line [MAXW];
    int          prev_lvl   = 0;
    bit [23:0]   prev_rgb   = '0;
    bit          hskip      = 1'b0;
    int          row_cnt    = 0;
    int          col_cnt    = 0;
    bit [11:0]   cfg_w      = 12'd640;
    bit [15:0]   cfg_h      = 16'd480;

    // bookkeeping
    int n_queued     = 0;
    int n_accepted   = 0;
    int n_results    = 0;
    int n_cfg_writes = 0;
    int err_cnt      = 0;
    int quiet_cycles = 0;

    // pacing state of each side
    int        tx_gap  = 0;
    int        tx_seg  = 0;
    bit        tx_calm = 1'b0;
    bit        tx_slot_free;
    pix_word_t tx_word;
    int        rx_stall = 0;
    int        rx_seg   = 0;
    bit        rx_calm  = 1'b0;

    zero_crossing_contour_overlay_top #(
        .MAX_WIDTH  (MAXW),
        .LEVEL_BITS (16)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_src_blue  (i_src_blue),
        .i_src_green (i_src_green),
        .i_src_red   (i_src_red),
        .i_level     (i_level),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_row   (o_out_row),
        .o_out_col   (o_out_col),
        .o_marked    (o_marked),
        .o_out_blue  (o_out_blue),
        .o_out_green (o_out_green),
        .o_out_red   (o_out_red),
        .o_run_last  (o_run_last),
        .o_frame_end (o_frame_end),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // shadow model of the marking logic
    // ---------------------------------------------------------------

    // zero width reads as one, oversize clamps to the line store depth
    function automatic int eff_width();
        if (cfg_w == 0) return 1;
        if (cfg_w > MAXW) return MAXW;
        return int'(cfg_w);
    endfunction

    function automatic int eff_height();
        return (cfg_h == 0) ? 1 : int'(cfg_h);
    endfunction

    // a pair crosses zero when one side is <= 0 and the other >= 0
    function automatic bit crosses(int a, int b);
        return (a <= 0 && b >= 0) || (a >= 0 && b <= 0);
    endfunction

    function automatic int magn(int a);
        return (a < 0) ? -a : a;
    endfunction

    function automatic void queue_result(int row, int col, bit mk, bit [23:0] rgb, bit fend);
        px_result_t res;
        res.row       = row[15:0];
        res.col       = col[10:0];
        res.marked    = mk;
        res.blue      = mk ? 8'd0 : rgb[7:0];
        res.green     = mk ? 8'd0 : rgb[15:8];
        res.red       = mk ? RED_FULL : rgb[23:16];
        res.run_last  = 1'b0;
        res.frame_end = fend;
        expected_px.push_back(res);
    endfunction

    // advance the shadow state by one pixel word, queueing what it describes
    function automatic void mark_contours(pix_word_t w);
        int        wd, ht, c, r, cur, n0;
        bit        lastcol, lastrow, vmark, nvsk, hm_prev, nh;
        bit [23:0] rgb;
        wd = eff_width();
        ht = eff_height();
        c = (col_cnt >= wd) ? wd - 1 : col_cnt;
        r = row_cnt;
        lastcol = (c + 1 >= wd);
        lastrow = (r + 1 >= ht);
        cur = $signed(w.level);
        rgb = {w.red, w.green, w.blue};
        n0 = expected_px.size();
        vmark = 1'b0;
        nvsk = 1'b0;

        // vertical pair with the stored row above, describes the upper pixel
        if (r > 0) begin
            if (!vskip_line[c] && crosses(lv_line[c], cur)) begin
                if (magn(lv_line[c]) < magn(cur)) vmark = 1'b1;
                else nvsk = 1'b1;
            end
            vmark = vmark || vskip_line[c];
            queue_result(r - 1, c, vmark || hmark_line[c], color_line[c], 1'b0);
        end

        // horizontal pair with the left neighbor
        if (c > 0) begin
            nh = 1'b0;
            hm_prev = hskip;
            if (!hskip && crosses(prev_lvl, cur)) begin
                if (magn(prev_lvl) < magn(cur)) hm_prev = 1'b1;
                else nh = 1'b1;
            end
            hmark_line[c - 1] = hm_prev;
            hskip = nh;
            if (lastrow)
                queue_result(r, c - 1, hm_prev || vskip_line[c - 1], prev_rgb, 1'b0);
        end else begin
            hskip = 1'b0;
        end

        vskip_line[c] = nvsk;
        lv_line[c]    = cur;
        color_line[c] = rgb;

        // last column flushes the pending horizontal mark
        if (lastcol) begin
            hmark_line[c] = hskip;
            if (lastrow)
                queue_result(r, c, hskip || nvsk, rgb, 1'b1);
            hskip = 1'b0;
        end

        prev_lvl = cur;
        prev_rgb = rgb;

        if (lastcol) begin
            col_cnt = 0;
            row_cnt = lastrow ? 0 : r + 1;
        end else begin
            col_cnt = c + 1;
        end

        if (expected_px.size() > n0)
            expected_px[$].run_last = 1'b1;
    endfunction

    // words still needed to close the frame, exact only once drained
    function automatic int pixels_left();
        int wd = eff_width();
        int ht = eff_height();
        int rows_after = (row_cnt >= ht - 1) ? 0 : ht - 1 - row_cnt;
        return ((col_cnt >= wd) ? 1 : wd - col_cnt) + rows_after * wd;
    endfunction

    // ---------------------------------------------------------------
    // pacing and random content
    // ---------------------------------------------------------------

    // each segment is either back-to-back traffic or random waits, drawn at random
    function automatic int draw_wait(inout int seg_left, inout bit calm);
        if (seg_left == 0) begin
            seg_left = $urandom_range(5, 40);
            calm = ($urandom_range(0, 2) == 0);
        end
        seg_left--;
        return calm ? 0 : $urandom_range(0, 14);
    endfunction

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // mostly near zero so that sign changes and ties are common
    function automatic logic [15:0] rand_level();
        int v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = int'($urandom_range(0, 8)) - 4;
            4, 5, 6:    v = int'($urandom_range(0, 600)) - 300;
            8: begin
                case ($urandom_range(0, 4))
                    0:       v = -32768;
                    1:       v = 32767;
                    2:       v = -1;
                    3:       v = 1;
                    default: v = 0;
                endcase
            end
            default:    v = int'($urandom_range(0, 65535));
        endcase
        return v[15:0];
    endfunction

    // ---------------------------------------------------------------
    // checking
    // ---------------------------------------------------------------

    task automatic report_mismatch(string msg);
        err_cnt++;
        if (err_cnt <= MAX_PRINTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d field %s got %0d want %0d",
                                      n_results, name, got, want));
    endtask

    // ---------------------------------------------------------------
    // pixel driver: one word from the queue at a time, held while stalled
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            tx_gap = 0;
        end else begin
            tx_slot_free = !i_in_valid;
            // word taken at this edge: predict it, then draw the wait before the next
            if (i_in_valid && !o_in_stall) begin
                mark_contours(tx_word);
                n_accepted++;
                tx_gap = draw_wait(tx_seg, tx_calm);
                tx_slot_free = 1'b1;
            end
            if (tx_slot_free) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    i_in_valid <= 1'b0;
                end else if (pixel_q.size() > 0) begin
                    tx_word = pixel_q.pop_front();
                    i_src_blue  <= tx_word.blue;
                    i_src_green <= tx_word.green;
                    i_src_red   <= tx_word.red;
                    i_level     <= tx_word.level;
                    i_in_valid  <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // result monitor: compares each taken word, then stalls a random while
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        px_result_t want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            rx_stall = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                n_results++;
                if (expected_px.size() == 0) begin
                    report_mismatch($sformatf("result %0d (row %0d col %0d) not expected",
                                              n_results, o_out_row, o_out_col));
                end else begin
                    want = expected_px.pop_front();
                    check_field("row",       o_out_row,   want.row);
                    check_field("col",       o_out_col,   want.col);
                    check_field("marked",    o_marked,    want.marked);
                    check_field("blue",      o_out_blue,  want.blue);
                    check_field("green",     o_out_green, want.green);
                    check_field("red",       o_out_red,   want.red);
                    check_field("run_last",  o_run_last,  want.run_last);
                    check_field("frame_end", o_frame_end, want.frame_end);
                end
                rx_stall = draw_wait(rx_seg, rx_calm);
            end
            if (rx_stall > 0) begin
                rx_stall--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // watchdog: too long without any word moving on any channel
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------

    task automatic push_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r,
                              logic [15:0] lvl);
        pix_word_t w;
        w.blue  = b;
        w.green = g;
        w.red   = r;
        w.level = lvl;
        pixel_q.push_back(w);
        n_queued++;
    endtask

    task automatic push_random(int n);
        repeat (n) push_pixel(rand_byte(), rand_byte(), rand_byte(), rand_level());
    endtask

    // sender holds off until every word is taken and every result is back,
    // then a settling wait for words that describe nothing yet
    task automatic wait_drained();
        while (n_accepted != n_queued || expected_px.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_IDX_WIDTH) cfg_w = val[11:0];
        else cfg_h = val;
        n_cfg_writes++;
    endtask

    task automatic set_frame(logic [15:0] wdata, logic [15:0] hdata);
        wait_drained();
        write_reg(CFG_IDX_WIDTH, wdata);
        write_reg(CFG_IDX_HEIGHT, hdata);
    endtask

    initial begin
        int   i, w, h, total, rand_items;
        bit   first;
        logic [15:0] lv;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // 4 x 3 frame with hand-picked crossings, colors at both extremes
        set_frame(16'd4, 16'd3);
        for (i = 0; i < 12; i++) begin
            lv = OPEN_LEVELS[i][15:0];
            push_pixel(i[0] ? 8'hFF : 8'h00, i[1] ? 8'hFF : 8'h00, rand_byte(), lv);
        end

        // zero width reads as one column; upper data bits are ignored
        set_frame(16'hF000, 16'd4);
        push_pixel(8'd1, 8'd2, 8'd3, 16'd5);
        push_pixel(8'd4, 8'd5, 8'd6, -16'sd5);
        push_pixel(8'd7, 8'd8, 8'd9, 16'd0);
        push_pixel(8'd10, 8'd11, 8'd12, -16'sd1);

        // zero height reads as one row, tie on the only pair
        set_frame(16'd2, 16'd0);
        push_pixel(8'hFF, 8'hFF, 8'hFF, -16'sd7);
        push_pixel(8'h00, 8'h00, 8'h00, 16'd7);

        // oversize width clamps; then width cut below the column count mid-row
        set_frame(16'hFFFF, 16'd1);
        push_pixel(rand_byte(), rand_byte(), rand_byte(), 16'd1);
        push_pixel(rand_byte(), rand_byte(), rand_byte(), -16'sd2);
        push_pixel(rand_byte(), rand_byte(), rand_byte(), 16'd3);
        push_pixel(rand_byte(), rand_byte(), rand_byte(), -16'sd4);
        push_pixel(rand_byte(), rand_byte(), rand_byte(), 16'd0);
        wait_drained();
        write_reg(CFG_IDX_WIDTH, 16'd3);
        push_pixel(rand_byte(), rand_byte(), rand_byte(), 16'd9);

        rand_items = 0;

        // tallest frame, then height cut below the row count mid-frame
        set_frame(16'd5, 16'hFFFF);
        push_random(15);
        wait_drained();
        write_reg(CFG_IDX_HEIGHT, 16'd2);
        rand_items += 15 + pixels_left();
        push_random(pixels_left());

        // widest line, cut short partway through the first row
        set_frame(16'd2048, 16'd2);
        push_random(7);
        wait_drained();
        write_reg(CFG_IDX_WIDTH, 16'd5);
        rand_items += 7 + pixels_left();
        push_random(pixels_left());

        // whole frames of random size, settings changed only between frames
        first = 1'b1;
        while (rand_items < RAND_ITEMS) begin
            if (first || $urandom_range(0, 2) == 0) begin
                w = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                                : $urandom_range(1, 12);
                h = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(1, 6);
                set_frame(16'(($urandom_range(0, 15) << 12) | w), 16'(h));
            end
            total = eff_width() * eff_height();
            // sometimes pause halfway until every result is back
            if (first || $urandom_range(0, 4) == 0) begin
                push_random(total / 2);
                wait_drained();
                push_random(total - total / 2);
            end else begin
                push_random(total);
            end
            rand_items += total;
            first = 1'b0;
        end

        wait_drained();
        repeat (20) @(posedge i_clk);

        $display("run: %0d pixel words sent, %0d results checked, %0d register writes",
                 n_accepted, n_results, n_cfg_writes);
        $display("run: clamped and zero sizes, mid-frame width and height cuts, random frames");
        if (err_cnt == 0) begin
            $display("All tests passed");
        end else begin
            $display("%0d mismatches", err_cnt);
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/zcco_pkg.sv
design/zcco_line_store.sv
design/zcco_marker.sv
design/zcco_result_fifo.sv
design/zero_crossing_contour_overlay_top.sv
test/zero_crossing_contour_overlay_top_tb.sv
